// ===== sv/pcsbd_pkg.sv =====
// ----------------------------------------------------------------------------
// pcsbd_pkg
// shared types, codes and constants of the pci class scan bar decoder
// ----------------------------------------------------------------------------
package pcsbd_pkg;

  // scan extent and bar count
  localparam int BUS_LIMIT   = 256;
  localparam int SLOT_LIMIT  = 32;
  localparam int FUNC_LIMIT  = 8;
  localparam int BAR_SLOTS   = 6;
  localparam int QUEUE_DEPTH = 2;

  localparam int BAR_IDX_W = 3;
  localparam logic [BAR_IDX_W-1:0] LAST_BAR = BAR_IDX_W'(BAR_SLOTS - 1);

  // input operation codes
  localparam logic OP_START    = 1'b0;
  localparam logic OP_RESPONSE = 1'b1;

  // configuration register indexes
  localparam logic CFG_TARGET_CLASS    = 1'b0;
  localparam logic CFG_TARGET_SUBCLASS = 1'b1;

  // config space offsets
  localparam logic [7:0] OFS_VENDOR = 8'h00;
  localparam logic [7:0] OFS_CLASS  = 8'h08;
  localparam logic [7:0] OFS_HEADER = 8'h0C;
  localparam logic [7:0] OFS_BAR0   = 8'h10;

  localparam logic [15:0] VENDOR_NONE = 16'hFFFF;
  localparam logic [31:0] IO_MASK     = 32'hFFFF_FFFC;
  localparam logic [31:0] MEM_MASK    = 32'hFFFF_FFF0;
  localparam logic [1:0]  MEM_TYPE_64 = 2'b10;

  localparam logic [7:0] CLASS_RESET    = 8'd1;
  localparam logic [7:0] SUBCLASS_RESET = 8'd6;

  typedef enum logic [1:0] {
    KIND_REQ      = 2'd0,
    KIND_BAR      = 2'd1,
    KIND_NOTFOUND = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_VENDOR = 3'd1,
    PH_CLASS  = 3'd2,
    PH_HEADER = 3'd3,
    PH_BAR    = 3'd4
  } phase_e;

  // description of the matched function
  typedef struct packed {
    logic [7:0]  bus;
    logic [4:0]  slot;
    logic [2:0]  func;
    logic [15:0] vendor;
    logic [15:0] device;
    logic [7:0]  prog_if;
    logic [7:0]  header;
  } meta_t;

  // one command from the front to the back
  typedef struct packed {
    kind_e       kind;
    logic [31:0] addr;
    meta_t       meta;
  } cmd_t;

  // one result item
  typedef struct packed {
    kind_e                 kind;
    logic [31:0]           addr;
    meta_t                 meta;
    logic [BAR_IDX_W-1:0]  bar_index;
    logic [63:0]           bar_value;
    logic                  last;
  } result_t;

  // back to front: bar store read port and report release
  typedef struct packed {
    logic [BAR_IDX_W-1:0] bar_idx;
    logic                 rpt_done;
  } bar_rd_t;

endpackage

// ===== sv/pcsbd_front.sv =====
// ----------------------------------------------------------------------------
// pcsbd_front
// scan sequencer: takes start and response transfers, walks bus/slot/func,
// decodes bars and queues request, report and not-found commands
// ----------------------------------------------------------------------------
module pcsbd_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [7:0]            cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  operation_i,
  input  logic [31:0]           read_data_i,
  output logic                  push_o,
  output pcsbd_pkg::cmd_t       cmd_o,
  input  logic                  q_full_i,
  input  pcsbd_pkg::bar_rd_t    bar_rd_i,
  output logic [63:0]           bar_data_o
);
  import pcsbd_pkg::*;

  typedef struct packed {
    logic [7:0] bus;
    logic [4:0] slot;
    logic [2:0] func;
    logic       wrap;
  } pos_t;

  function automatic logic [31:0] cfg_addr(logic [7:0] b, logic [4:0] s, logic [2:0] f,
                                           logic [7:0] ofs);
    return {1'b1, 7'b0, b, s, f, ofs[7:2], 2'b00};
  endfunction

  function automatic pos_t scan_next(logic [7:0] b, logic [4:0] s, logic [2:0] f,
                                     logic skip);
    pos_t p;
    p = '{bus: b, slot: s, func: f, wrap: 1'b0};
    if (skip || f == 3'(FUNC_LIMIT - 1)) begin
      p.func = '0;
      if (s == 5'(SLOT_LIMIT - 1)) begin
        p.slot = '0;
        if (b == 8'(BUS_LIMIT - 1)) begin
          p.bus  = '0;
          p.wrap = 1'b1;
        end else begin
          p.bus = b + 8'd1;
        end
      end else begin
        p.slot = s + 5'd1;
      end
    end else begin
      p.func = f + 3'd1;
    end
    return p;
  endfunction

  phase_e phase_q, phase_d;
  logic [7:0]  tclass_q, tclass_d, tsub_q, tsub_d;
  logic [7:0]  bus_q, bus_d;
  logic [4:0]  slot_q, slot_d;
  logic [2:0]  func_q, func_d;
  logic [15:0] vendor_q, vendor_d, device_q, device_d;
  logic [7:0]  prog_if_q, prog_if_d, header_q, header_d;
  logic        matched_q, matched_d;
  logic [BAR_IDX_W-1:0] cursor_q, cursor_d;
  logic        high_q, high_d;
  logic        rpt_busy_q, rpt_busy_d;
  logic [63:0] bar_q [BAR_SLOTS];
  logic [63:0] bar_d [BAR_SLOTS];

  logic                 accept;
  logic                 adv_en, adv_skip, rpt_en, req_en;
  logic [7:0]           req_ofs;
  logic [BAR_IDX_W-1:0] cur_p1, cur_p2, cur_n;
  pos_t                 nxt;

  // hold input while the queue is full, or in the bar phase while reports still read the bar store
  assign in_stall_o = q_full_i || (phase_q == PH_BAR && rpt_busy_q);
  assign accept     = in_valid_i && !in_stall_o;
  assign bar_data_o = bar_q[bar_rd_i.bar_idx];

  assign cur_p1 = cursor_q + BAR_IDX_W'(1);
  assign cur_p2 = cursor_q + BAR_IDX_W'(2);

  always_comb begin
    phase_d    = phase_q;
    tclass_d   = tclass_q;
    tsub_d     = tsub_q;
    bus_d      = bus_q;
    slot_d     = slot_q;
    func_d     = func_q;
    vendor_d   = vendor_q;
    device_d   = device_q;
    prog_if_d  = prog_if_q;
    header_d   = header_q;
    matched_d  = matched_q;
    cursor_d   = cursor_q;
    high_d     = high_q;
    rpt_busy_d = rpt_busy_q && !bar_rd_i.rpt_done;
    bar_d      = bar_q;
    adv_en     = 1'b0;
    adv_skip   = 1'b0;
    rpt_en     = 1'b0;
    req_en     = 1'b0;
    req_ofs    = OFS_VENDOR;
    cur_n      = cursor_q;
    push_o     = 1'b0;
    cmd_o      = '{kind: KIND_REQ, addr: '0, meta: '0};
    nxt        = scan_next(bus_q, slot_q, func_q, 1'b0);

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TARGET_CLASS:    tclass_d = cfg_wdata_i;
        CFG_TARGET_SUBCLASS: tsub_d   = cfg_wdata_i;
        default:             tclass_d = tclass_q;
      endcase
    end

    if (accept) begin
      if (operation_i == OP_START) begin
        bus_d     = '0;
        slot_d    = '0;
        func_d    = '0;
        matched_d = 1'b0;
        cursor_d  = '0;
        high_d    = 1'b0;
        phase_d   = PH_VENDOR;
        push_o    = 1'b1;
        cmd_o.addr = cfg_addr('0, '0, '0, OFS_VENDOR);
      end else begin
        unique case (phase_q)
          PH_VENDOR: begin
            if (read_data_i[15:0] == VENDOR_NONE) begin
              adv_en   = 1'b1;
              adv_skip = (func_q == '0);
            end else begin
              vendor_d = read_data_i[15:0];
              device_d = read_data_i[31:16];
              phase_d  = PH_CLASS;
              req_en   = 1'b1;
              req_ofs  = OFS_CLASS;
            end
          end
          PH_CLASS: begin
            prog_if_d = read_data_i[15:8];
            matched_d = (read_data_i[31:24] == tclass_q) && (read_data_i[23:16] == tsub_q);
            phase_d   = PH_HEADER;
            req_en    = 1'b1;
            req_ofs   = OFS_HEADER;
          end
          PH_HEADER: begin
            header_d = read_data_i[23:16];
            if (!matched_q) begin
              adv_en = 1'b1;
            end else begin
              cursor_d = '0;
              high_d   = 1'b0;
              phase_d  = PH_BAR;
              req_en   = 1'b1;
              req_ofs  = OFS_BAR0;
            end
          end
          PH_BAR: begin
            if (cursor_q >= BAR_IDX_W'(BAR_SLOTS)) begin
              rpt_en = 1'b1;
            end else begin
              if (high_q) begin
                bar_d[cursor_q][63:32] = read_data_i;
                if (cur_p1 < BAR_IDX_W'(BAR_SLOTS)) begin
                  bar_d[cur_p1] = '0;
                end
                high_d = 1'b0;
                cur_n  = cur_p2;
              end else if (read_data_i[0]) begin
                bar_d[cursor_q] = {32'b0, read_data_i & IO_MASK};
                cur_n = cur_p1;
              end else begin
                bar_d[cursor_q] = {32'b0, read_data_i & MEM_MASK};
                cur_n = cur_p1;
                // wide memory bar: fetch the high word next
                if (read_data_i[2:1] == MEM_TYPE_64 && cur_p1 < BAR_IDX_W'(BAR_SLOTS)) begin
                  high_d = 1'b1;
                  cur_n  = cursor_q;
                end
              end
              cursor_d = cur_n;
              if (high_d) begin
                req_en  = 1'b1;
                req_ofs = OFS_BAR0 + {3'b0, cur_p1, 2'b00};
              end else if (cur_n >= BAR_IDX_W'(BAR_SLOTS)) begin
                rpt_en = 1'b1;
              end else begin
                req_en  = 1'b1;
                req_ofs = OFS_BAR0 + {3'b0, cur_n, 2'b00};
              end
            end
          end
          default: begin
            // response while idle is dropped
            phase_d = phase_q;
          end
        endcase

        if (req_en) begin
          push_o     = 1'b1;
          cmd_o.addr = cfg_addr(bus_q, slot_q, func_q, req_ofs);
        end

        if (adv_en) begin
          nxt    = scan_next(bus_q, slot_q, func_q, adv_skip);
          bus_d  = nxt.bus;
          slot_d = nxt.slot;
          func_d = nxt.func;
          push_o = 1'b1;
          if (nxt.wrap) begin
            phase_d    = PH_IDLE;
            cmd_o.kind = KIND_NOTFOUND;
          end else begin
            phase_d    = PH_VENDOR;
            cmd_o.addr = cfg_addr(nxt.bus, nxt.slot, nxt.func, OFS_VENDOR);
          end
        end

        if (rpt_en) begin
          phase_d    = PH_IDLE;
          rpt_busy_d = 1'b1;
          push_o     = 1'b1;
          cmd_o.kind = KIND_BAR;
          cmd_o.meta = '{bus: bus_q, slot: slot_q, func: func_q, vendor: vendor_q,
                         device: device_q, prog_if: prog_if_q, header: header_q};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      tclass_q   <= CLASS_RESET;
      tsub_q     <= SUBCLASS_RESET;
      bus_q      <= '0;
      slot_q     <= '0;
      func_q     <= '0;
      vendor_q   <= '0;
      device_q   <= '0;
      prog_if_q  <= '0;
      header_q   <= '0;
      matched_q  <= 1'b0;
      cursor_q   <= '0;
      high_q     <= 1'b0;
      rpt_busy_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      tclass_q   <= tclass_d;
      tsub_q     <= tsub_d;
      bus_q      <= bus_d;
      slot_q     <= slot_d;
      func_q     <= func_d;
      vendor_q   <= vendor_d;
      device_q   <= device_d;
      prog_if_q  <= prog_if_d;
      header_q   <= header_d;
      matched_q  <= matched_d;
      cursor_q   <= cursor_d;
      high_q     <= high_d;
      rpt_busy_q <= rpt_busy_d;
    end
  end

  // bar store payload, written before it is read
  always_ff @(posedge clk_i) begin
    bar_q <= bar_d;
  end

endmodule

// ===== sv/pcsbd_queue.sv =====
// ----------------------------------------------------------------------------
// pcsbd_queue
// short command fifo between the scan sequencer and the result stage
// ----------------------------------------------------------------------------
module pcsbd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pcsbd_pkg::cmd_t cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output pcsbd_pkg::cmd_t head_o
);
  import pcsbd_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  cmd_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_LAST) ? '0 : wr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_LAST) ? '0 : rd_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

// ===== sv/pcsbd_back.sv =====
// ----------------------------------------------------------------------------
// pcsbd_back
// result stage: drains commands into the output register, expanding a
// report command into one bar report per bar slot
// ----------------------------------------------------------------------------
module pcsbd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  pcsbd_pkg::cmd_t     q_head_i,
  output logic                pop_o,
  output pcsbd_pkg::bar_rd_t  bar_rd_o,
  input  logic [63:0]         bar_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pcsbd_pkg::result_t  res_o
);
  import pcsbd_pkg::*;

  logic                 out_valid_q, out_valid_d;
  result_t              res_q, res_d;
  logic                 rpt_active_q, rpt_active_d;
  logic [BAR_IDX_W-1:0] rpt_idx_q, rpt_idx_d;
  meta_t                rpt_meta_q, rpt_meta_d;

  logic                 load, emit_rpt, rpt_done;
  logic [BAR_IDX_W-1:0] src_idx;
  meta_t                src_meta;

  assign load     = !out_valid_q || !out_stall_i;
  assign src_idx  = rpt_active_q ? rpt_idx_q : '0;
  assign src_meta = rpt_active_q ? rpt_meta_q : q_head_i.meta;
  assign bar_rd_o = '{bar_idx: src_idx, rpt_done: rpt_done};

  always_comb begin
    out_valid_d  = out_valid_q;
    res_d        = res_q;
    rpt_active_d = rpt_active_q;
    rpt_idx_d    = rpt_idx_q;
    rpt_meta_d   = rpt_meta_q;
    pop_o        = 1'b0;
    emit_rpt     = 1'b0;
    rpt_done     = 1'b0;

    if (load) begin
      out_valid_d = 1'b0;
      if (rpt_active_q) begin
        emit_rpt = 1'b1;
      end else if (q_valid_i) begin
        pop_o = 1'b1;
        unique case (q_head_i.kind)
          KIND_REQ: begin
            out_valid_d = 1'b1;
            res_d       = '{kind: KIND_REQ, addr: q_head_i.addr, meta: '0,
                            bar_index: '0, bar_value: '0, last: 1'b0};
          end
          KIND_NOTFOUND: begin
            out_valid_d = 1'b1;
            res_d       = '{kind: KIND_NOTFOUND, addr: '0, meta: '0,
                            bar_index: '0, bar_value: '0, last: 1'b1};
          end
          KIND_BAR: emit_rpt = 1'b1;
          default:  pop_o = 1'b1;
        endcase
      end

      if (emit_rpt) begin
        out_valid_d = 1'b1;
        res_d       = '{kind: KIND_BAR, addr: '0, meta: src_meta, bar_index: src_idx,
                        bar_value: bar_data_i, last: (src_idx == LAST_BAR)};
        if (src_idx == LAST_BAR) begin
          rpt_active_d = 1'b0;
          rpt_done     = 1'b1;
        end else begin
          rpt_active_d = 1'b1;
          rpt_idx_d    = src_idx + BAR_IDX_W'(1);
          rpt_meta_d   = src_meta;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      rpt_active_q <= 1'b0;
      rpt_idx_q    <= '0;
    end else begin
      out_valid_q  <= out_valid_d;
      rpt_active_q <= rpt_active_d;
      rpt_idx_q    <= rpt_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q      <= res_d;
    rpt_meta_q <= rpt_meta_d;
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

// ===== sv/pci_class_scan_bar_decoder.sv =====
// ----------------------------------------------------------------------------
// pci_class_scan_bar_decoder
// brute-force pci enumeration by class/subclass with bar decode
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                 payload
// -------   ---------  ------------------------  ------------------------------
// cfg       in         cfg_we_i                  cfg_idx_i, cfg_wdata_i
// in        in         in_valid_i / in_stall_o   operation_i, read_data_i
// out       out        out_valid_o / out_stall_i kind_o .. last_o (12 fields)
//
// one input transfer per cycle when not stalled, each handled in the scan sequencer
// results leave through a registered output stage once the command reaches the
// head of the two-entry command queue
// a bar report run gives one output transfer for each of the six bar slots, read from the bar store
// the input stalls while the command queue is full, and in the bar phase
// while a report run is still reading the bar store
// reset is asynchronous, active low; no clearing pass
//
// ----------------------------------------------------------------------------
module pci_class_scan_bar_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  // start and config read response transfers
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [31:0] read_data_i,
  // result transfers
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [31:0] pci_address_o,
  output logic [7:0]  bus_number_o,
  output logic [4:0]  slot_number_o,
  output logic [2:0]  function_number_o,
  output logic [15:0] vendor_code_o,
  output logic [15:0] device_code_o,
  output logic [7:0]  prog_interface_o,
  output logic [7:0]  header_kind_o,
  output logic [2:0]  bar_index_o,
  output logic [63:0] bar_value_o,
  output logic        last_o
);
  import pcsbd_pkg::*;

  // front to queue
  logic    push;
  cmd_t    push_cmd;
  logic    q_full;
  // queue to back
  logic    q_valid;
  logic    pop;
  cmd_t    q_head;
  // bar store read by the back, owned by the front
  bar_rd_t bar_rd;
  logic [63:0] bar_data;
  result_t res;

  // scan sequencer: classifies each response and decodes bars
  pcsbd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .read_data_i (read_data_i),
    .push_o      (push),
    .cmd_o       (push_cmd),
    .q_full_i    (q_full),
    .bar_rd_i    (bar_rd),
    .bar_data_o  (bar_data)
  );

  // decouples input acceptance from output stalls
  pcsbd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  // result stage with the output register
  pcsbd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .pop_o       (pop),
    .bar_rd_o    (bar_rd),
    .bar_data_i  (bar_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  // fields of the result register
  assign kind_o            = res.kind;
  assign pci_address_o     = res.addr;
  assign bus_number_o      = res.meta.bus;
  assign slot_number_o     = res.meta.slot;
  assign function_number_o = res.meta.func;
  assign vendor_code_o     = res.meta.vendor;
  assign device_code_o     = res.meta.device;
  assign prog_interface_o  = res.meta.prog_if;
  assign header_kind_o     = res.meta.header;
  assign bar_index_o       = res.bar_index;
  assign bar_value_o       = res.bar_value;
  assign last_o            = res.last;

endmodule

// ===== sv/pcsbd_checker.sv =====
// ----------------------------------------------------------------------------
// pcsbd_checker
// port-level checks on the result channel of the scan bar decoder
// ----------------------------------------------------------------------------
module pcsbd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  kind_o,
  input logic [31:0] pci_address_o,
  input logic [2:0]  bar_index_o,
  input logic [63:0] bar_value_o,
  input logic        last_o
);
  import pcsbd_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) &&
      $stable(pci_address_o) && $stable(bar_value_o) && $stable(last_o))
    else $error("stalled result changed");

  // requests carry the enable bit and a dword offset, never last
  a_req_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_REQ |->
      pci_address_o[31] && pci_address_o[1:0] == 2'b00 && !last_o)
    else $error("malformed config read request");

  // not-found closes a run
  a_nf_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_NOTFOUND |-> last_o && bar_value_o == '0)
    else $error("not-found result without last");

  // reports end on the final bar slot
  a_rpt_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_BAR |-> last_o == (bar_index_o == LAST_BAR))
    else $error("bar report last flag wrong");

  // a report transfer that is not last is followed by the next bar index
  a_rpt_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && kind_o == KIND_BAR && !last_o ##1 out_valid_o |->
      kind_o == KIND_BAR && bar_index_o == $past(bar_index_o) + 3'd1)
    else $error("bar report run broken");

endmodule

bind pci_class_scan_bar_decoder pcsbd_checker u_pcsbd_checker (.*);
